[rtl/ihtc_pkg.sv]
// Shared types and constants for the IPv4/TCP header checker.
package ihtc_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [3:0]  IpVersion4  = 4'd4;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [15:0] MinIpHeader = 16'd20;
  localparam logic [6:0]  MinTcpHdr   = 7'd20;
  localparam logic [15:0] SumGood     = 16'hFFFF;
  localparam logic [15:0] CountMax    = 16'hFFFF;

  localparam logic [2:0] StatusTcpOk     = 3'd0;
  localparam logic [2:0] StatusUndersize = 3'd1;
  localparam logic [2:0] StatusBadVer    = 3'd2;
  localparam logic [2:0] StatusBadSum    = 3'd3;
  localparam logic [2:0] StatusTruncated = 3'd4;
  localparam logic [2:0] StatusNotTcp    = 3'd5;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] offset_and_flags;
    logic [31:0] sequence_number;
    logic [31:0] acknowledge_number;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } out_item_t;

  // Per-packet summary handed from the parser to the verdict stage.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] ones_sum;
    logic [5:0]  header_bytes;
    logic        version_wrong;
    logic [15:0] total_length;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [15:0] offset_flags;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
  } pkt_rec_t;

endpackage

[rtl/ihtc_front.sv]
// Byte parser: counts bytes, sums the IP header, captures header fields.
module ihtc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  ihtc_pkg::in_item_t in_item_i,
  output logic              rec_valid_o,
  output ihtc_pkg::pkt_rec_t rec_o
);

  logic [15:0] cnt_q, cnt_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic [5:0]  hb_q, hb_d;
  logic        vw_q, vw_d;
  logic [15:0] tot_q, tot_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [31:0] ports_q, ports_d;
  logic [15:0] offf_q, offf_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] ack_q, ack_d;

  logic        accept;
  logic        first;
  logic [7:0]  b;
  logic        in_hdr;
  logic        tcp_en;
  logic [15:0] tcp_idx;
  logic [16:0] sum_wide;

  assign accept = push & ~full;
  assign b      = in_item_i.byte_in;
  assign first  = (cnt_q == 16'd0);

  always_comb begin
    hb_d     = first ? {b[3:0], 2'b00} : hb_q;
    vw_d     = first ? (b[7:4] != ihtc_pkg::IpVersion4) : vw_q;
    in_hdr   = (cnt_q < {10'd0, hb_d});
    sum_wide = {1'b0, sum_q} + {1'b0, pend_q, b};
    sum_d    = sum_q;
    pend_d   = pend_q;
    if (in_hdr) begin
      if (cnt_q[0]) begin
        sum_d = sum_wide[15:0] + {15'd0, sum_wide[16]};
      end else begin
        pend_d = b;
      end
    end

    tot_d   = (cnt_q == 16'd2 || cnt_q == 16'd3) ? {tot_q[7:0], b} : tot_q;
    proto_d = (cnt_q == 16'd9) ? b : proto_q;
    src_d   = (cnt_q >= 16'd12 && cnt_q <= 16'd15) ? {src_q[23:0], b} : src_q;
    dst_d   = (cnt_q >= 16'd16 && cnt_q <= 16'd19) ? {dst_q[23:0], b} : dst_q;

    // TCP header starts at the IHL offset
    tcp_en  = (cnt_q >= {10'd0, hb_d}) && (cnt_q != ihtc_pkg::CountMax);
    tcp_idx = cnt_q - {10'd0, hb_d};
    ports_d = ports_q;
    seq_d   = seq_q;
    ack_d   = ack_q;
    offf_d  = offf_q;
    if (tcp_en) begin
      if (tcp_idx <= 16'd3) begin
        ports_d = {ports_q[23:0], b};
      end else if (tcp_idx <= 16'd7) begin
        seq_d = {seq_q[23:0], b};
      end else if (tcp_idx <= 16'd11) begin
        ack_d = {ack_q[23:0], b};
      end else if (tcp_idx <= 16'd13) begin
        offf_d = {offf_q[7:0], b};
      end
    end

    cnt_d = (cnt_q == ihtc_pkg::CountMax) ? cnt_q : cnt_q + 16'd1;
  end

  always_comb begin
    rec_valid_o        = accept & in_item_i.last_byte;
    rec_o.byte_count   = cnt_d;
    rec_o.ones_sum     = sum_d;
    rec_o.header_bytes = hb_d;
    rec_o.version_wrong = vw_d;
    rec_o.total_length = tot_d;
    rec_o.protocol     = proto_d;
    rec_o.src_addr     = src_d;
    rec_o.dst_addr     = dst_d;
    rec_o.ports        = ports_d;
    rec_o.offset_flags = offf_d;
    rec_o.seq_num      = seq_d;
    rec_o.ack_num      = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      pend_q  <= '0;
      hb_q    <= '0;
      vw_q    <= 1'b0;
      tot_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ports_q <= '0;
      offf_q  <= '0;
      seq_q   <= '0;
      ack_q   <= '0;
    end else if (accept) begin
      if (in_item_i.last_byte) begin
        // packet done, start fresh
        cnt_q   <= '0;
        sum_q   <= '0;
        pend_q  <= '0;
        hb_q    <= '0;
        vw_q    <= 1'b0;
        tot_q   <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        ports_q <= '0;
        offf_q  <= '0;
        seq_q   <= '0;
        ack_q   <= '0;
      end else begin
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
        pend_q  <= pend_d;
        hb_q    <= hb_d;
        vw_q    <= vw_d;
        tot_q   <= tot_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        ports_q <= ports_d;
        offf_q  <= offf_d;
        seq_q   <= seq_d;
        ack_q   <= ack_d;
      end
    end
  end

endmodule

[rtl/ihtc_fifo.sv]
// Small register queue of packet summaries between parser and verdict stage.
module ihtc_fifo #(
  parameter int unsigned Depth = ihtc_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  ihtc_pkg::pkt_rec_t wr_data_i,
  output logic               full_o,
  input  logic               rd_en_i,
  output logic               valid_o,
  output ihtc_pkg::pkt_rec_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ihtc_pkg::pkt_rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntFull);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/ihtc_back.sv]
// Verdict stage: status priority, payload fields, result register.
module ihtc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  ihtc_pkg::pkt_rec_t  rec_i,
  output logic                rec_take_o,
  output logic                empty,
  input  logic                pop,
  output ihtc_pkg::out_item_t result_o
);

  logic                valid_q, valid_d;
  ihtc_pkg::out_item_t res_q, res_d;
  logic [2:0]          status;
  logic [5:0]          tcp_len;
  logic [6:0]          hdr_sum;
  logic [6:0]          hdr_min;

  assign rec_take_o = rec_valid_i & (~valid_q | pop);

  always_comb begin
    tcp_len = {rec_i.offset_flags[15:12], 2'b00};
    hdr_sum = {1'b0, rec_i.header_bytes} + {1'b0, tcp_len};
    hdr_min = {1'b0, rec_i.header_bytes} + ihtc_pkg::MinTcpHdr;

    if (rec_i.byte_count < ihtc_pkg::MinIpHeader) begin
      status = ihtc_pkg::StatusUndersize;
    end else if (rec_i.version_wrong) begin
      status = ihtc_pkg::StatusBadVer;
    end else if (rec_i.byte_count < {10'd0, rec_i.header_bytes}) begin
      status = ihtc_pkg::StatusTruncated;
    end else if (rec_i.ones_sum != ihtc_pkg::SumGood) begin
      status = ihtc_pkg::StatusBadSum;
    end else if (rec_i.total_length > rec_i.byte_count) begin
      status = ihtc_pkg::StatusTruncated;
    end else if (rec_i.protocol != ihtc_pkg::ProtoTcp) begin
      status = ihtc_pkg::StatusNotTcp;
    end else if (rec_i.byte_count < {9'd0, hdr_min}) begin
      status = ihtc_pkg::StatusTruncated;
    end else begin
      status = ihtc_pkg::StatusTcpOk;
    end

    res_d.status             = status;
    res_d.source_address     = rec_i.src_addr;
    res_d.dest_address       = rec_i.dst_addr;
    res_d.source_port        = rec_i.ports[31:16];
    res_d.dest_port          = rec_i.ports[15:0];
    res_d.offset_and_flags   = rec_i.offset_flags;
    res_d.sequence_number    = rec_i.seq_num;
    res_d.acknowledge_number = rec_i.ack_num;
    res_d.payload_offset     = {9'd0, hdr_sum};
    res_d.payload_length     = (rec_i.total_length > {9'd0, hdr_sum}) ?
                               rec_i.total_length - {9'd0, hdr_sum} : 16'd0;

    if (rec_take_o) begin
      valid_d = 1'b1;
    end else if (pop) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      res_q <= res_d;
    end
  end

  assign empty    = ~valid_q;
  assign result_o = res_q;

endmodule

[rtl/ipv4_tcp_header_checker_top.sv]
// Top level of the IPv4 header checker with TCP field extraction.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------
//  bytes    | in        | push / full             | in_item_i  (byte, last mark)
//  results  | out       | empty / pop             | result_o   (verdict, fields)
//
// One byte is taken per cycle while full is low; the byte parser updates its
// counters and the running ones-complement sum on the edge that takes it.
// The edge that takes a last byte writes the packet summary into the queue;
// it moves into the verdict stage's output register once that register is
// empty or being popped, and empty then drops.
// Reset (rst_ni low, asynchronous) clears parser state, queue pointers and
// the result valid flag.
// full is registered and rises only with QueueDepth summaries queued behind an
// unpopped result; a byte offered then waits until the verdict stage drains.
module ipv4_tcp_header_checker_top #(
  parameter int unsigned QueueDepth = ihtc_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ihtc_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output ihtc_pkg::out_item_t result_o
);

  logic               front_rec_valid;
  ihtc_pkg::pkt_rec_t front_rec;
  logic               q_valid;
  ihtc_pkg::pkt_rec_t q_rec;
  logic               q_take;

  // Parser: one transfer per byte, emits a packet summary on the last byte.
  ihtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .rec_valid_o (front_rec_valid),
    .rec_o       (front_rec)
  );

  // Decouples the parser from a stalled result consumer.
  ihtc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_rec_valid),
    .wr_data_i (front_rec),
    .full_o    (full),
    .rd_en_i   (q_take),
    .valid_o   (q_valid),
    .rd_data_o (q_rec)
  );

  // Verdict and payload arithmetic, registered onto the result ports.
  ihtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_i       (q_rec),
    .rec_take_o  (q_take),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule
